### rtl/assert_macros.svh
// Assertion macros used by the RTL of the ignition timing block.
// Every macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The expression must never be true at a clock edge.
`define ASSERT_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### rtl/cdi_pkg.sv
// Package for the ignition timing block: field widths, fixed arithmetic constants,
// register codes, the result record and the advance curve. Depends on nothing.
`timescale 1ns / 1ps

package cdi_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int RPM_W      = 16;
	localparam int IDX_W      = 5;
	localparam int DELAY_W    = 16;
	localparam int ANGLE_W    = 10;
	localparam int FALLBACK_W = 5;
	localparam int ROM_W      = 7;
	localparam int ROM_DEPTH  = 17;
	localparam int ROM_ADDR_W = 6;
	localparam int DIFF_W     = 10;
	localparam int CONST_W    = 24;

	// Register codes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_REV_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CUT       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DWELL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FALLBACK  = 3'd4;

	// rpm = RPM_NUMERATOR / interval for a 4 us tick.
	localparam logic [CONST_W-1:0] RPM_NUMERATOR     = 24'd15000000;
	localparam logic [CONST_W-1:0] IDX_ROUND         = 24'd125;
	localparam logic [CONST_W-1:0] IDX_STEP          = 24'd250;
	localparam logic [CONST_W-1:0] INTERVAL_STEP     = 24'd360;
	localparam logic [CONST_W-1:0] IDX_PLAUSIBLE_MAX = 24'd44;
	localparam logic [RPM_W-1:0]   RPM_MAX           = 16'hFFFF;
	localparam logic [DELAY_W-1:0] DELAY_MAX         = 16'hFFFF;

	// Advance curve in quarter degrees.
	localparam logic [ROM_W-1:0] ADVANCE_CURVE [ROM_DEPTH] = '{
		7'd40, 7'd40, 7'd40, 7'd40, 7'd40, 7'd45, 7'd50, 7'd55, 7'd60,
		7'd65, 7'd70, 7'd75, 7'd80, 7'd85, 7'd90, 7'd95, 7'd100
	};

	typedef struct packed {
		logic               ignition;
		logic               spark;
		logic               cut;
		logic [RPM_W-1:0]   rpm;
		logic [IDX_W-1:0]   index;
		logic [DELAY_W-1:0] delay;
	} result_t;

	// An index past the end of the curve reads its last entry.
	function automatic logic [ROM_W-1:0] advance_q(input logic [ROM_ADDR_W-1:0] idx);
		logic [ROM_W-1:0] val;
		if (idx >= ROM_ADDR_W'(ROM_DEPTH)) begin
			val = ADVANCE_CURVE[ROM_DEPTH-1];
		end else begin
			val = ADVANCE_CURVE[idx[4:0]];
		end
		return val;
	endfunction

endpackage

### rtl/cdi_ignition_timing.sv
// Ignition timing controller with rpm advance map and rev limiter; one input transfer per tick.
// A tick without a fresh trigger edge pushes its result straight into the output buffer; ticks
// are taken one per cycle while no reading is in work and the skid entry is free. A fresh edge
// goes through three divisions on the shared bit-serial divider and then the multiplier.
// Reset (arst_n low, asynchronous) restores register defaults, clears the timer and marks stale.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdi_ignition_timing import cdi_pkg::*; #(
	parameter int MAP_ENTRIES = 17,
	parameter int TIMER_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Tick channel.
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  trigger_level,
	// Result channel.
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  ignition_out,
	output logic                  led_out,
	output logic                  spark_fired,
	output logic                  rev_cut,
	output logic [RPM_W-1:0]      rpm_value,
	output logic [IDX_W-1:0]      advance_index,
	output logic [DELAY_W-1:0]    delay_value,
	// Configuration writes.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int TW      = TIMER_BITS;
	localparam int CmpW    = (TW > 16) ? TW : 16;
	localparam int DivW    = (TW > CONST_W) ? TW : CONST_W;
	localparam int DvsW    = (TW > 9) ? TW : 9;
	localparam int IdxCapW = $clog2(MAP_ENTRIES);
	localparam int ProdW   = DivW + DIFF_W;
	localparam logic [IdxCapW-1:0] IdxCap = IdxCapW'(MAP_ENTRIES - 1);

	// Sequencer: idle takes ticks; the others walk one fresh reading through the arithmetic units.
	typedef enum logic [2:0] {
		S_IDLE,
		S_RPM,
		S_IDX,
		S_QUO,
		S_MUL
	} state_t;

	// Ignition phase as seen on the pins.
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DWELL,
		PH_CUT
	} phase_t;

	// Configuration registers.
	logic [15:0]           rev_limit_q;
	logic [15:0]           cut_ticks_q;
	logic [15:0]           dwell_ticks_q;
	logic [ANGLE_W-1:0]    angle_q;
	logic [FALLBACK_W-1:0] fallback_q;

	// Controller state.
	state_t              state_q;
	phase_t              phase_q;
	logic [TW-1:0]       timer_q;
	logic                stale_q;
	logic                prev_q;
	logic [TW-1:0]       interval_q;
	logic [RPM_W-1:0]    rpm_q;
	logic [IdxCapW-1:0]  index_q;
	logic [DELAY_W-1:0]  delay_q;

	// Shared unit handshakes and operands.
	logic                div_start_q;
	logic [DivW-1:0]     div_dvd_q;
	logic [DvsW-1:0]     div_dvs_q;
	logic                div_done;
	logic [DivW-1:0]     div_quo;
	logic                mul_start_q;
	logic [DivW-1:0]     mul_a_q;
	logic [DIFF_W-1:0]   mul_b_q;
	logic                mul_done;
	logic [ProdW-1:0]    mul_prod;

	// Tick logic.
	logic                accept;
	logic                rise;
	logic [TW-1:0]       timer_inc;
	logic                wrapped;
	logic                dwell_over;
	logic                cut_over;
	logic [TW-1:0]       timer_nxt;
	logic                stale_nxt;
	phase_t              phase_nxt;
	logic                go;
	logic                push;
	logic                spark;

	// Arithmetic on the unit results.
	logic [RPM_W-1:0]    rpm_sat;
	logic [IdxCapW-1:0]  index_sel;
	logic [ROM_W-1:0]    advance;
	logic [DIFF_W-1:0]   diff_pos;
	logic [DELAY_W-1:0]  delay_sat;
	logic [DELAY_W-1:0]  delay_res;

	result_t             res;
	result_t             out_res;
	logic                buf_full;

	// Configuration writes land at any edge and are meant for times when no reading is in
	// work; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_limit_q   <= 16'd10000;
			cut_ticks_q   <= 16'd10000;
			dwell_ticks_q <= 16'd1000;
			angle_q       <= ANGLE_W'(100);
			fallback_q    <= FALLBACK_W'(9);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REV_LIMIT: rev_limit_q   <= cfg_data;
				REG_CUT:       cut_ticks_q   <= cfg_data;
				REG_DWELL:     dwell_ticks_q <= cfg_data;
				REG_ANGLE:     angle_q       <= cfg_data[ANGLE_W-1:0];
				REG_FALLBACK:  fallback_q    <= cfg_data[FALLBACK_W-1:0];
				default:       ;
			endcase
		end
	end

	// A new tick is taken only while no reading is in work and the skid entry is free, so
	// the result of any tick always finds room in the buffer.
	assign in_stall = (state_q != S_IDLE) | buf_full;
	assign accept   = in_valid & ~in_stall;

	assign rise       = trigger_level & ~prev_q;
	assign timer_inc  = timer_q + 1'b1;
	assign wrapped    = (timer_inc == '0);
	assign dwell_over = wrapped | (CmpW'(timer_inc) >= CmpW'(dwell_ticks_q));
	assign cut_over   = wrapped | (CmpW'(timer_inc) >= CmpW'(cut_ticks_q));

	// One tick: the timer advances (a wrap marks the reading stale), an active phase may end,
	// and in the idle phase a rising edge restarts the timer and, for a fresh reading, captures
	// the interval, which goes to the arithmetic sequence; its result follows at the end.
	always_comb begin
		timer_nxt = timer_inc;
		stale_nxt = stale_q | wrapped;
		phase_nxt = phase_q;
		go        = 1'b0;
		push      = 1'b0;
		spark     = 1'b0;
		if (state_q == S_IDLE && accept) begin
			push = 1'b1;
			case (phase_q)
				PH_DWELL: begin
					if (dwell_over) begin
						phase_nxt = PH_IDLE;
					end
				end
				PH_CUT: begin
					if (cut_over) begin
						stale_nxt = 1'b1;
						phase_nxt = PH_IDLE;
					end
				end
				PH_IDLE: begin
					if (rise) begin
						timer_nxt = '0;
						if (stale_nxt) begin
							// The edge after a stale period only restarts the measurement.
							stale_nxt = 1'b0;
						end else begin
							go   = 1'b1;
							push = 1'b0;
						end
					end
				end
				default: phase_nxt = PH_IDLE;
			endcase
		end else if (state_q == S_MUL && mul_done) begin
			push = 1'b1;
			if (rpm_q > rev_limit_q) begin
				phase_nxt = PH_CUT;
			end else begin
				phase_nxt = PH_DWELL;
				spark     = 1'b1;
			end
		end
	end

	// rpm saturates, and a zero interval (timer wrap) reads as the maximum.
	always_comb begin
		if (interval_q == '0 || div_quo > DivW'(RPM_MAX)) begin
			rpm_sat = RPM_MAX;
		end else begin
			rpm_sat = div_quo[RPM_W-1:0];
		end
	end

	// An implausibly high index falls back to the configured one; all indexes stop at the cap.
	always_comb begin
		if (div_quo > DivW'(IDX_PLAUSIBLE_MAX)) begin
			if (ROM_ADDR_W'(fallback_q) > ROM_ADDR_W'(IdxCap)) begin
				index_sel = IdxCap;
			end else begin
				index_sel = IdxCapW'(fallback_q);
			end
		end else if (div_quo > DivW'(IdxCap)) begin
			index_sel = IdxCap;
		end else begin
			index_sel = IdxCapW'(div_quo);
		end
	end

	// A trigger angle at or behind the advance gives no delay, so only a positive
	// difference goes to the multiplier.
	assign advance = advance_q(ROM_ADDR_W'(index_q));
	always_comb begin
		if (angle_q > ANGLE_W'(advance)) begin
			diff_pos = DIFF_W'(angle_q - ANGLE_W'(advance));
		end else begin
			diff_pos = '0;
		end
	end

	// Quarter degrees to ticks: drop two bits, then saturate.
	always_comb begin
		if (|mul_prod[ProdW-1:DELAY_W+2]) begin
			delay_sat = DELAY_MAX;
		end else begin
			delay_sat = mul_prod[DELAY_W+1:2];
		end
	end

	assign delay_res = (state_q == S_MUL) ? delay_sat : delay_q;

	// Sequencer and tick state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_IDLE;
			timer_q     <= '0;
			stale_q     <= 1'b1;
			prev_q      <= 1'b0;
			interval_q  <= '0;
			rpm_q       <= '0;
			index_q     <= '0;
			delay_q     <= '0;
			div_start_q <= 1'b0;
			div_dvd_q   <= '0;
			div_dvs_q   <= '0;
			mul_start_q <= 1'b0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
		end else begin
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;
			phase_q     <= phase_nxt;
			if (accept) begin
				timer_q <= timer_nxt;
				stale_q <= stale_nxt;
				prev_q  <= trigger_level;
			end
			case (state_q)
				S_IDLE: begin
					if (go) begin
						interval_q  <= timer_inc;
						div_dvd_q   <= DivW'(RPM_NUMERATOR);
						div_dvs_q   <= DvsW'(timer_inc);
						div_start_q <= 1'b1;
						state_q     <= S_RPM;
					end
				end
				S_RPM: begin
					if (div_done) begin
						rpm_q       <= rpm_sat;
						div_dvd_q   <= DivW'(rpm_sat) + DivW'(IDX_ROUND);
						div_dvs_q   <= DvsW'(IDX_STEP);
						div_start_q <= 1'b1;
						state_q     <= S_IDX;
					end
				end
				S_IDX: begin
					if (div_done) begin
						index_q     <= index_sel;
						div_dvd_q   <= DivW'(interval_q);
						div_dvs_q   <= DvsW'(INTERVAL_STEP);
						div_start_q <= 1'b1;
						state_q     <= S_QUO;
					end
				end
				S_QUO: begin
					if (div_done) begin
						mul_a_q     <= div_quo;
						mul_b_q     <= diff_pos;
						mul_start_q <= 1'b1;
						state_q     <= S_MUL;
					end
				end
				S_MUL: begin
					if (mul_done) begin
						delay_q <= delay_sat;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	cdi_div #(
		.DW (DivW),
		.VW (DvsW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dvd_q),
		.divisor  (div_dvs_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	cdi_mul #(
		.AW (DivW),
		.BW (DIFF_W)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.mcand   (mul_a_q),
		.mplier  (mul_b_q),
		.done    (mul_done),
		.product (mul_prod)
	);

	always_comb begin
		res.ignition = (phase_nxt == PH_DWELL);
		res.spark    = spark;
		res.cut      = (phase_nxt == PH_CUT);
		res.rpm      = rpm_q;
		res.index    = IDX_W'(index_q);
		res.delay    = delay_res;
	end

	cdi_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_res),
		.full      (buf_full)
	);

	assign ignition_out  = out_res.ignition;
	assign led_out       = out_res.ignition;
	assign spark_fired   = out_res.spark;
	assign rev_cut       = out_res.cut;
	assign rpm_value     = out_res.rpm;
	assign advance_index = out_res.index;
	assign delay_value   = out_res.delay;

	`ASSERT_NEVER(a_fire_during_cut, out_valid && ignition_out && rev_cut, "ignition driven during a rev cut")
	`ASSERT_CLK(a_spark_starts_dwell, out_valid && spark_fired |-> ignition_out, "spark without dwell")
	`ASSERT_CLK(a_cut_end_stale, $fell(phase_q == PH_CUT) |-> stale_q, "rev cut ended with a fresh reading")
	`ASSERT_NEVER(a_index_capped, index_q > IdxCap, "map index beyond the last entry")

endmodule

### rtl/cdi_div.sv
// Bit-serial restoring divider: one quotient bit per clock cycle.
// Standalone; used by the ignition timing top level for all three divisions.
`timescale 1ns / 1ps

module cdi_div #(
	parameter int DW = 24,
	parameter int VW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CntW = $clog2(DW + 1);

	logic [DW-1:0]   dvd_q;
	logic [VW-1:0]   dvs_q;
	logic [VW-1:0]   rem_q;
	logic [CntW-1:0] cnt_q;
	logic            done_q;
	logic [VW:0]     rem_sh;
	logic [VW:0]     rem_nxt;
	logic            ge;

	always_comb begin
		rem_sh  = {rem_q, dvd_q[DW-1]};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_nxt = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CntW'(DW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend register fills with quotient bits from the bottom as it shifts.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DW-2:0], ge};
			rem_q <= rem_nxt[VW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

### rtl/cdi_mul.sv
// Bit-serial shift-and-add multiplier: one bit of the multiplier per clock cycle.
// Standalone; used by the ignition timing top level for the spark delay.
`timescale 1ns / 1ps

module cdi_mul #(
	parameter int AW = 24,
	parameter int BW = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    mcand,
	input  logic [BW-1:0]    mplier,
	output logic             done,
	output logic [AW+BW-1:0] product
);

	localparam int PW   = AW + BW;
	localparam int CntW = $clog2(BW + 1);

	logic [PW-1:0]   mcand_q;
	logic [BW-1:0]   mplier_q;
	logic [PW-1:0]   acc_q;
	logic [CntW-1:0] cnt_q;
	logic            done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CntW'(BW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= PW'(mcand);
			mplier_q <= mplier;
			acc_q    <= '0;
		end else if (cnt_q != '0) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[PW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[BW-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

### rtl/cdi_obuf.sv
// Two-entry result buffer: an output register with a skid entry behind it.
// Depends on cdi_pkg for the result record.
`timescale 1ns / 1ps

module cdi_obuf import cdi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	input  logic    out_stall,
	output logic    out_valid,
	output result_t out_data,
	output logic    full
);

	logic    o_valid_q;
	logic    k_valid_q;
	result_t o_data_q;
	result_t k_data_q;
	logic    pop;

	assign pop = o_valid_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
			k_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				o_valid_q <= k_valid_q | push;
				k_valid_q <= k_valid_q & push;
			end else if (push) begin
				o_valid_q <= 1'b1;
				k_valid_q <= o_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (k_valid_q) begin
				o_data_q <= k_data_q;
				k_data_q <= push_data;
			end else begin
				o_data_q <= push_data;
			end
		end else if (push) begin
			if (o_valid_q) begin
				k_data_q <= push_data;
			end else begin
				o_data_q <= push_data;
			end
		end
	end

	assign out_valid = o_valid_q;
	assign out_data  = o_data_q;
	assign full      = k_valid_q;

endmodule
